FILE: hdl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W     = $clog2(SLOTS + 1);
  localparam int GEN_W       = 24;
  localparam int FIELD_W     = 8;
  localparam int HANDLE_W    = GEN_W + FIELD_W;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;

  localparam logic [GEN_W-1:0] GEN_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    CMD_OPEN        = 2'd0,
    CMD_LOOKUP      = 2'd1,
    CMD_RELEASE     = 2'd2,
    CMD_RELEASE_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle;
  } op_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_W-1:0]    new_handle;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [COUNT_OUT_W-1:0] open_slots;
  } res_t;

endpackage

FILE: hdl/ght_slot_table.sv
`timescale 1ns / 1ps

module ght_slot_table import ght_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  op_t  op,
  output res_t res
);

  logic [SLOTS-1:0]      active;
  logic [GEN_W-1:0]      generation [SLOTS];
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;

  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [FIELD_W-1:0]    field;
  logic [FIELD_W-1:0]    field_m1;
  logic [GEN_W-1:0]      hgen;
  logic                  field_ok;
  logic [SLOT_IDX_W-1:0] hdl_idx;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic [GEN_W-1:0]      gen_rd;
  logic [GEN_W-1:0]      gen_inc;
  logic                  handle_ok;
  logic [FIELD_W-1:0]    new_field;
  logic [31:0]           idx_wide;
  logic [31:0]           count_wide;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign field    = op.handle[FIELD_W-1:0];
  assign hgen     = op.handle[HANDLE_W-1:FIELD_W];
  assign field_m1 = field - 8'd1;
  assign hdl_idx  = field_m1[SLOT_IDX_W-1:0];
  assign field_ok = (field != '0) && ({1'b0, field} <= 9'(SLOTS));

  assign rd_idx    = (op.command == CMD_OPEN) ? free_idx : hdl_idx;
  assign gen_rd    = generation[rd_idx];
  assign gen_inc   = (gen_rd == GEN_MAX) ? GEN_W'(1) : gen_rd + GEN_W'(1);
  assign handle_ok = field_ok && (hgen != '0) && active[hdl_idx] && (gen_rd == hgen);
  assign new_field = FIELD_W'(free_idx) + 8'd1;

  always_comb begin
    res.status     = ST_OK;
    res.new_handle = '0;
    idx_wide       = '0;
    count_next     = count;
    unique case (op.command)
      CMD_OPEN: begin
        if (free_found) begin
          res.new_handle = {gen_inc, new_field};
          count_next     = count + COUNT_W'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_LOOKUP, CMD_RELEASE: begin
        if (handle_ok) begin
          idx_wide = 32'(hdl_idx);
          if (op.command == CMD_RELEASE && count != '0) begin
            count_next = count - COUNT_W'(1);
          end
        end else begin
          res.status = ST_BAD;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
    count_wide     = 32'(count_next);
    res.slot_index = idx_wide[SLOT_OUT_W-1:0];
    res.open_slots = count_wide[COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      count  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        generation[i] <= '0;
      end
    end else if (en) begin
      count <= count_next;
      unique case (op.command)
        CMD_OPEN: begin
          if (free_found) begin
            active[free_idx]     <= 1'b1;
            generation[free_idx] <= gen_inc;
          end
        end
        CMD_LOOKUP: begin
        end
        CMD_RELEASE: begin
          if (handle_ok) begin
            active[hdl_idx] <= 1'b0;
          end
        end
        default: begin
          active <= '0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/generational_handle_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Words
// command   in         cmd_valid / cmd_ready  command, handle
// response  out        rsp_valid / rsp_ready  status, new_handle, slot_index, open_slots
//
// Each word passes an input register and is resolved combinationally against the
// slot table as it advances, landing in the response register.
// One word is taken per cycle while responses drain; the first-free search
// and generation compare are combinational.
// Reset clears all active bits, generations and the live count at once.
// A stalled response holds both registers and drops cmd_ready once they fill.

module generational_handle_table import ght_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [1:0]             command,
  input  logic [HANDLE_W-1:0]    handle,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [1:0]             status,
  output logic [HANDLE_W-1:0]    new_handle,
  output logic [SLOT_OUT_W-1:0]  slot_index,
  output logic [COUNT_OUT_W-1:0] open_slots
);

  logic s1_valid;
  op_t  s1_op;
  logic advance;
  res_t res;
  res_t rsp;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1_op.command <= command;
      s1_op.handle  <= handle;
    end
  end

  ght_slot_table u_table (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .op  (s1_op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= res;
    end
  end

  assign status     = rsp.status;
  assign new_handle = rsp.new_handle;
  assign slot_index = rsp.slot_index;
  assign open_slots = rsp.open_slots;

endmodule

FILE: hdl/ght_checker.sv
`timescale 1ns / 1ps

module ght_checker import ght_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [1:0]             status,
  input logic [HANDLE_W-1:0]    new_handle,
  input logic [SLOT_OUT_W-1:0]  slot_index,
  input logic [COUNT_OUT_W-1:0] open_slots
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(new_handle)
      && $stable(slot_index) && $stable(open_slots))
    else $error("Response word changed while stalled.");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> new_handle == '0 && slot_index == '0)
    else $error("Failed command returned a handle or slot.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> open_slots == COUNT_OUT_W'(SLOTS))
    else $error("Table full reported with free slots.");

  a_open_gen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && new_handle != '0 |->
      new_handle[HANDLE_W-1:FIELD_W] != '0 && new_handle[FIELD_W-1:0] != '0
      && status == ST_OK)
    else $error("Issued handle has zero generation or slot field.");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .status     (status),
  .new_handle (new_handle),
  .slot_index (slot_index),
  .open_slots (open_slots)
);

FILE: bench/generational_handle_table_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_CYCLES = 8;
  localparam int WORDS_PER_PHASE = 270;
  localparam int HOLD_CYCLES = 64;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] word_handle;
    logic [4:0]          reps;
    logic                pinned;
    res_t                rsp;
  } script_row_t;

  localparam int SCRIPT_LEN = 16;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_OPEN,        32'h0000_0000, 5'd1,  1'b1, '{ST_OK,   32'h0000_0101, 4'd0,  5'd1}},
    '{CMD_LOOKUP,      32'h0000_0101, 5'd1,  1'b1, '{ST_OK,   32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_LOOKUP,      32'h0000_0100, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_LOOKUP,      32'h0000_0111, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_LOOKUP,      32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_RELEASE,     32'h0000_0001, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_RELEASE,     32'h0000_0201, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd1}},
    '{CMD_RELEASE,     32'h0000_0101, 5'd1,  1'b1, '{ST_OK,   32'h0000_0000, 4'd0,  5'd0}},
    '{CMD_RELEASE,     32'h0000_0101, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd0}},
    '{CMD_OPEN,        32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,   32'h0000_0201, 4'd0,  5'd1}},
    '{CMD_OPEN,        32'h0000_0000, 5'd15, 1'b0, '{ST_OK,   32'h0000_0000, 4'd0,  5'd0}},
    '{CMD_OPEN,        32'h0000_0000, 5'd1,  1'b1, '{ST_FULL, 32'h0000_0000, 4'd0,  5'd16}},
    '{CMD_LOOKUP,      32'h0000_0110, 5'd1,  1'b1, '{ST_OK,   32'h0000_0000, 4'd15, 5'd16}},
    '{CMD_RELEASE_ALL, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,   32'h0000_0000, 4'd0,  5'd0}},
    '{CMD_LOOKUP,      32'h0000_0110, 5'd1,  1'b1, '{ST_BAD,  32'h0000_0000, 4'd0,  5'd0}},
    '{CMD_RELEASE_ALL, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,   32'h0000_0000, 4'd0,  5'd0}}
  };

  localparam int PHASES = 4;
  localparam int SEND_IDLE_PCT [PHASES] = '{0, 68, 0, 19};
  localparam int RSP_STALL_PCT [PHASES] = '{0, 0, 68, 19};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_ready;
  logic [1:0]             command = CMD_OPEN;
  logic [HANDLE_W-1:0]    handle = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  logic [1:0]             status;
  logic [HANDLE_W-1:0]    new_handle;
  logic [SLOT_OUT_W-1:0]  slot_index;
  logic [COUNT_OUT_W-1:0] open_slots;

  // Slot table as the block should hold it after every accepted word.
  bit               slot_live [SLOTS];
  logic [GEN_W-1:0] slot_gen [SLOTS];
  int unsigned      live_total;

  res_t        pending_rsp [$];
  logic        offer_pinned = 1'b0;
  res_t        offer_rsp = '0;
  int          send_idle_pct;
  int          rsp_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  int unsigned full_seen = 0;
  int unsigned bad_seen = 0;
  int unsigned input_stalls = 0;

  generational_handle_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .command    (command),
    .handle     (handle),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .new_handle (new_handle),
    .slot_index (slot_index),
    .open_slots (open_slots)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic res_t resolve_command(input logic [1:0] cmd,
                                           input logic [HANDLE_W-1:0] h);
    res_t r;
    int found;
    int unsigned field;
    logic [GEN_W-1:0] gen;
    bit valid;
    r = '0;
    r.status = ST_OK;
    unique case (cmd)
      CMD_OPEN: begin
        found = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_live[i]) found = i;
        end
        if (found < 0) begin
          r.status = ST_FULL;
        end else begin
          gen = (slot_gen[found] == GEN_MAX) ? GEN_W'(1) : slot_gen[found] + 1'b1;
          slot_gen[found] = gen;
          slot_live[found] = 1'b1;
          live_total++;
          r.new_handle = {gen, FIELD_W'(found + 1)};
        end
      end
      CMD_LOOKUP, CMD_RELEASE: begin
        field = h[FIELD_W-1:0];
        gen = h[HANDLE_W-1:FIELD_W];
        valid = field != 0 && field <= SLOTS && gen != '0;
        if (valid) valid = slot_live[field-1] && slot_gen[field-1] == gen;
        if (!valid) begin
          r.status = ST_BAD;
        end else begin
          r.slot_index = SLOT_OUT_W'(field - 1);
          if (cmd == CMD_RELEASE) begin
            slot_live[field-1] = 1'b0;
            if (live_total != 0) live_total--;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            slot_live[i] = 1'b0;
            if (live_total != 0) live_total--;
          end
        end
      end
    endcase
    r.open_slots = COUNT_OUT_W'(live_total);
    return r;
  endfunction

  // Mostly handles of live slots, some stale or corrupted, some noise.
  task automatic draw_command(output cmd_t c, output logic [HANDLE_W-1:0] h);
    int unsigned roll;
    int unsigned sub;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    pick = $urandom_range(0, SLOTS - 1);
    h = $urandom;
    for (int k = 0; k < SLOTS; k++) begin
      if (!slot_live[pick]) pick = (pick + 1) % SLOTS;
    end
    if (roll < 34) begin
      c = CMD_OPEN;
    end else if (roll < 97) begin
      c = (roll < 66) ? CMD_LOOKUP : CMD_RELEASE;
      if (sub < 7) begin
        h = {slot_gen[pick], FIELD_W'(pick + 1)};
      end else if (sub == 7) begin
        h = {slot_gen[pick] ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1)),
             FIELD_W'(pick + 1)};
      end else if (sub == 8) begin
        h[FIELD_W-1:0] = FIELD_W'($urandom_range(0, SLOTS + 1));
      end
    end else begin
      c = CMD_RELEASE_ALL;
    end
  endtask

  // Entered and left at a falling edge; valid stays high between back-to-back words.
  task automatic offer_word(input cmd_t c, input logic [HANDLE_W-1:0] h,
                            input logic pinned, input res_t rsp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= c;
    handle <= h;
    offer_pinned <= pinned;
    offer_rsp <= rsp;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    errors++;
    if (errors <= REPORT_MAX) begin
      $write("%s: expected status %0d handle %h slot %0d count %0d, ",
             what, want.status, want.new_handle, want.slot_index, want.open_slots);
      $display("got status %0d handle %h slot %0d count %0d",
               got.status, got.new_handle, got.slot_index, got.open_slots);
    end
  endtask

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= $urandom_range(0, 99) >= rsp_stall_pct;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t predicted;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_rsp.size());
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        got = {status, new_handle, slot_index, open_slots};
        checked++;
        if (got.status == ST_FULL) full_seen++;
        if (got.status == ST_BAD) bad_seen++;
        if (pending_rsp.size() == 0) begin
          note_mismatch("response with nothing outstanding", '0, got);
        end else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status || got.new_handle !== want.new_handle ||
              got.slot_index !== want.slot_index || got.open_slots !== want.open_slots) begin
            note_mismatch("response mismatch", want, got);
          end
        end
      end
      if (cmd_valid && !cmd_ready) input_stalls++;
      if (cmd_valid && cmd_ready) begin
        predicted = resolve_command(command, handle);
        pending_rsp.push_back(offer_pinned ? offer_rsp : predicted);
        cmd_seen[command]++;
      end
    end
  end

  initial begin
    cmd_t c;
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
    end
    live_total = 0;
    send_idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      for (int n = 0; n < SCRIPT[r].reps; n++) begin
        offer_word(SCRIPT[r].cmd, SCRIPT[r].word_handle, SCRIPT[r].pinned, SCRIPT[r].rsp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      rsp_stall_pct <= RSP_STALL_PCT[p];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // A long response stall while words keep coming fills the pipeline.
        if (p == 0 && n == 40) hold_requests <= hold_requests + 1;
        draw_command(c, h);
        offer_word(c, h, 1'b0, '0);
      end
    end
    cmd_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display(
      "Covered %0d opens, %0d lookups, %0d releases, %0d release-alls; %0d responses checked.",
      cmd_seen[CMD_OPEN], cmd_seen[CMD_LOOKUP], cmd_seen[CMD_RELEASE],
      cmd_seen[CMD_RELEASE_ALL], checked);
    $display("Saw %0d full-table and %0d rejected-handle responses, input stalled %0d cycles.",
             full_seen, bad_seen, input_stalls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
